// File: rtl/core/brf_pkg.sv
// ----------------------------------------------------------------------------
// brf_pkg
// Shared widths, limits and polynomial coefficients for the bisection root
// finder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package brf_pkg;

  localparam int FRAC_BITS      = 24;
  localparam int MAX_ITERATIONS = 64;
  localparam int X_W            = 32;
  localparam int ACC_W          = 64;
  localparam int MAG_W          = ACC_W - 1;
  localparam int TOL_W          = 25;
  localparam int ITER_W         = $clog2(MAX_ITERATIONS + 1);
  localparam int TERMS          = 4;
  localparam int TERM_W         = $clog2(TERMS);
  localparam int MUL_SHIFT      = X_W - FRAC_BITS;
  localparam int HALF_W         = 32;

  localparam logic [MAG_W-1:0]        MAG_MAX   = '1;
  localparam logic [TOL_W-1:0]        TOL_RESET = TOL_W'(1678);
  localparam logic [ITER_W-1:0]       ITER_CAP  = ITER_W'(MAX_ITERATIONS);

  localparam logic signed [ACC_W-1:0] ONE    = ACC_W'(1) <<< FRAC_BITS;
  // leading coefficient of 2x^4 - 5x^3 + x^2 + 4x - 4
  localparam logic signed [ACC_W-1:0] C_LEAD = ONE <<< 1;

  // coefficients added after each Horner multiply, highest power first
  function automatic logic signed [ACC_W-1:0] coef(input logic [TERM_W-1:0] idx);
    logic signed [ACC_W-1:0] c;
    unique case (idx)
      2'd0: c = -((ONE <<< 2) + ONE);
      2'd1: c = ONE;
      2'd2: c = ONE <<< 2;
      2'd3: c = -(ONE <<< 2);
    endcase
    return c;
  endfunction

endpackage

// File: rtl/core/brf_poly.sv
// ----------------------------------------------------------------------------
// brf_poly
// Horner evaluation of the quartic on one shared 32x32 multiplier, with
// symmetric saturation of the Q40.24 accumulator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module brf_poly
  import brf_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [X_W-1:0]   x,
  output logic                    done,
  output logic signed [ACC_W-1:0] result
);

  typedef enum logic [2:0] {
    P_IDLE,
    P_MAG,
    P_MUL_LO,
    P_MUL_HI,
    P_SCALE,
    P_ADD
  } pstate_t;

  localparam logic signed [ACC_W:0] POS_LIM = {2'b00, MAG_MAX};
  localparam logic signed [ACC_W:0] NEG_LIM = -POS_LIM;

  pstate_t                 state;
  logic signed [ACC_W-1:0] acc;
  logic                    acc_neg;
  logic [MAG_W-1:0]        mag;
  logic [X_W-1:0]          mx;
  logic                    x_neg;
  logic [TERM_W-1:0]       term;
  logic [ACC_W-1:0]        lp;
  logic [ACC_W-1:0]        hp;
  logic [MAG_W-1:0]        rmag;
  logic                    rneg;

  logic [HALF_W-1:0]       mul_a;
  logic [ACC_W-1:0]        prod;
  logic                    hp_ovf;
  logic [ACC_W:0]          tsum;
  logic [MAG_W-1:0]        scaled;
  logic signed [ACC_W:0]   coef_ext;
  logic signed [ACC_W:0]   rmag_ext;
  logic signed [ACC_W:0]   asum;
  logic signed [ACC_W-1:0] acc_next;

  // the one multiplier: low half of the magnitude first, then the high half
  assign mul_a = (state == P_MUL_LO) ? mag[HALF_W-1:0] : HALF_W'(mag[MAG_W-1:HALF_W]);
  assign prod  = ACC_W'(mul_a) * ACC_W'(mx);

  always_comb begin
    hp_ovf = (hp >> (MAG_W - MUL_SHIFT)) != '0;
    tsum   = (ACC_W + 1)'(hp << MUL_SHIFT) + (ACC_W + 1)'(lp >> FRAC_BITS);
    if (hp_ovf || (tsum > (ACC_W + 1)'(MAG_MAX))) begin
      scaled = MAG_MAX;
    end else begin
      scaled = tsum[MAG_W-1:0];
    end
  end

  always_comb begin
    coef_ext = (ACC_W + 1)'(coef(term));
    rmag_ext = signed'({2'b00, rmag});
    asum     = rneg ? (coef_ext - rmag_ext) : (coef_ext + rmag_ext);
    priority if (asum > POS_LIM) begin
      acc_next = ACC_W'(POS_LIM);
    end else if (asum < NEG_LIM) begin
      acc_next = ACC_W'(NEG_LIM);
    end else begin
      acc_next = asum[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= P_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == P_ADD) && (term == TERM_W'(TERMS - 1));
      unique case (state)
        P_IDLE: begin
          if (start) begin
            acc   <= C_LEAD;
            x_neg <= x[X_W-1];
            mx    <= x[X_W-1] ? X_W'(-x) : X_W'(x);
            term  <= '0;
            state <= P_MAG;
          end
        end
        P_MAG: begin
          acc_neg <= acc[ACC_W-1];
          mag     <= acc[ACC_W-1] ? MAG_W'(-acc) : MAG_W'(acc);
          state   <= P_MUL_LO;
        end
        P_MUL_LO: begin
          lp    <= prod;
          state <= P_MUL_HI;
        end
        P_MUL_HI: begin
          hp    <= prod;
          state <= P_SCALE;
        end
        P_SCALE: begin
          rmag  <= scaled;
          rneg  <= acc_neg ^ x_neg;
          state <= P_ADD;
        end
        P_ADD: begin
          acc  <= acc_next;
          term <= term + TERM_W'(1);
          if (term == TERM_W'(TERMS - 1)) begin
            state <= P_IDLE;
          end else begin
            state <= P_MAG;
          end
        end
        default: state <= P_IDLE;
      endcase
    end
  end

  assign result = acc;

endmodule

// File: rtl/core/bisection_root_finder.sv
// ----------------------------------------------------------------------------
// bisection_root_finder
// Bisects a Q8.24 interval toward a root of 2x^4 - 5x^3 + x^2 + 4x - 4.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) takes lower_bound and upper_bound, both
// signed Q8.24. Output channel (out_valid/out_ready) returns root (last
// midpoint), iterations (steps taken, 1..64) and converged. The config
// channel (cfg_valid/cfg_ready/cfg_data) sets the tolerance on |p(mid)|;
// it is always ready and should only be written while the block is idle.
// One interval is worked at a time; in_ready is high only between jobs.
// Each polynomial evaluation runs four Horner terms, each through the
// magnitude, low product, high product, scale and add states, with two
// partial products per term on the single 32x32 multiplier. An interval
// costs two evaluations up front, then per bisection step one step
// state, one evaluation and one check state. The result is offered, and
// in_ready is back, in the same cycle once the output register is free.
// The finished result sits in an output register, so a new interval is
// taken while the receiver stalls; a second result waits until it drains.
// Synchronous reset returns to idle, drops out_valid and sets the
// tolerance to 1678 (about 1e-4).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bisection_root_finder
  import brf_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [TOL_W-1:0]        cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [X_W-1:0]   lower_bound,
  input  logic signed [X_W-1:0]   upper_bound,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [X_W-1:0]   root,
  output logic [ITER_W-1:0]       iterations,
  output logic                    converged
);

  typedef enum logic [2:0] {
    T_IDLE,
    T_POLY_LO,
    T_POLY_MID,
    T_STEP,
    T_CHECK,
    T_FINISH
  } tstate_t;

  tstate_t                 state;
  logic [TOL_W-1:0]        tol;
  logic signed [X_W-1:0]   lo;
  logic signed [X_W-1:0]   hi;
  logic signed [X_W-1:0]   mid;
  logic signed [ACC_W-1:0] p_lo;
  logic signed [ACC_W-1:0] p_mid;
  logic [ITER_W-1:0]       steps;
  logic                    first;
  logic                    conv;
  logic                    pstart;
  logic signed [X_W-1:0]   px;

  logic                    pdone;
  logic signed [ACC_W-1:0] presult;

  logic signed [X_W:0]     in_sum;
  logic signed [X_W-1:0]   in_mid;
  logic                    lo_zero;
  logic                    mid_zero;
  logic                    go_low;
  logic                    go_high;
  logic signed [X_W-1:0]   lo_next;
  logic signed [X_W-1:0]   hi_next;
  logic signed [X_W:0]     step_sum;
  logic signed [X_W-1:0]   mid_next;
  logic signed [ACC_W-1:0] tol_s;
  logic                    within_tol;

  brf_poly u_poly (
    .clk    (clk),
    .rst    (rst),
    .start  (pstart),
    .x      (px),
    .done   (pdone),
    .result (presult)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == T_IDLE);

  // floor((a + b) / 2) via arithmetic shift of the widened sum
  assign in_sum = (X_W + 1)'(lower_bound) + (X_W + 1)'(upper_bound);
  assign in_mid = X_W'(in_sum >>> 1);

  always_comb begin
    lo_zero  = (p_lo == '0);
    mid_zero = (p_mid == '0);
    go_low   = !lo_zero && !mid_zero && (p_lo[ACC_W-1] == p_mid[ACC_W-1]);
    go_high  = !lo_zero && !mid_zero && (p_lo[ACC_W-1] != p_mid[ACC_W-1]);
    lo_next  = go_low ? mid : lo;
    hi_next  = go_high ? mid : hi;
    step_sum = (X_W + 1)'(lo_next) + (X_W + 1)'(hi_next);
    mid_next = X_W'(step_sum >>> 1);
  end

  assign tol_s      = signed'(ACC_W'(tol));
  assign within_tol = (p_mid <= tol_s) && (p_mid >= -tol_s);

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= TOL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      tol <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= T_IDLE;
      pstart    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      pstart <= ((state == T_IDLE) && in_valid) || ((state == T_POLY_LO) && pdone) ||
                (state == T_STEP);
      if ((state == T_FINISH) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        T_IDLE: begin
          if (in_valid) begin
            lo     <= lower_bound;
            hi     <= upper_bound;
            mid    <= in_mid;
            steps  <= '0;
            first  <= 1'b1;
            px     <= lower_bound;
            state  <= T_POLY_LO;
          end
        end
        T_POLY_LO: begin
          if (pdone) begin
            p_lo   <= presult;
            px     <= mid;
            state  <= T_POLY_MID;
          end
        end
        T_POLY_MID: begin
          if (pdone) begin
            p_mid <= presult;
            first <= 1'b0;
            state <= first ? T_STEP : T_CHECK;
          end
        end
        T_STEP: begin
          lo    <= lo_next;
          hi    <= hi_next;
          mid   <= mid_next;
          steps <= steps + ITER_W'(1);
          if (go_low) begin
            p_lo <= p_mid;
          end
          px     <= mid_next;
          state  <= T_POLY_MID;
        end
        T_CHECK: begin
          priority if (within_tol) begin
            conv  <= 1'b1;
            state <= T_FINISH;
          end else if (steps == ITER_CAP) begin
            conv  <= 1'b0;
            state <= T_FINISH;
          end else begin
            state <= T_STEP;
          end
        end
        T_FINISH: begin
          // hold until the output register is free
          if (!out_valid || out_ready) begin
            root       <= mid;
            iterations <= steps;
            converged  <= conv;
            state      <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

endmodule

// File: verif/bisection_root_finder_test.sv
// ----------------------------------------------------------------------------
// bisection_root_finder_test
// Self-checking bench for the bisection root finder. Intervals go in over a
// valid/ready channel with random gaps, results come back under random
// stalls, and each one is checked field by field against a bit-accurate
// bisection model kept in the bench. The tolerance register is set to 1.0,
// zero, random values and its reset value between phases, with the block drained.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bisection_root_finder_test;
  import brf_pkg::*;

  localparam int LIMIT_CYCLES = 6_000_000;
  localparam int END_HOLD     = 2000;
  localparam int PHASE_ITEMS  = 115;
  localparam int Q1           = 1 << FRAC_BITS;

  localparam logic signed [X_W-1:0]   X_MIN   = {1'b1, {(X_W-1){1'b0}}};
  localparam logic signed [X_W-1:0]   X_MAX   = {1'b0, {(X_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_HI  = {1'b0, MAG_MAX};
  localparam logic [ACC_W-1:0]        MAG_TOP = {1'b0, MAG_MAX};
  localparam logic signed [ACC_W-1:0] Q_ONE   = 64'sd1 <<< FRAC_BITS;
  localparam logic [TOL_W-1:0]        TOL_TOP = TOL_W'(1 << FRAC_BITS);

  typedef struct {
    logic signed [X_W-1:0] lower;
    logic signed [X_W-1:0] upper;
  } interval_t;

  typedef struct {
    logic signed [X_W-1:0] root;
    logic [ITER_W-1:0]     iterations;
    logic                  converged;
  } bisect_result_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [TOL_W-1:0]      cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic signed [X_W-1:0] lower_bound = '0;
  logic signed [X_W-1:0] upper_bound = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic signed [X_W-1:0] root;
  logic [ITER_W-1:0]     iterations;
  logic                  converged;

  interval_t      pending_intervals[$];
  bisect_result_t pending_roots[$];
  logic [TOL_W-1:0] tolerance_now = TOL_RESET;

  bit in_taken   = 1'b0;
  bit out_taken  = 1'b0;
  bit holding    = 1'b0;
  int send_gap   = 0;
  int send_calm  = 0;
  int stall_left = 0;
  int recv_calm  = 0;
  int fails      = 0;
  int cycles     = 0;

  bisection_root_finder u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .lower_bound (lower_bound),
    .upper_bound (upper_bound),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .root        (root),
    .iterations  (iterations),
    .converged   (converged)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- model

  function automatic logic signed [ACC_W-1:0] sat_sum(input logic signed [ACC_W-1:0] a,
                                                      input logic signed [ACC_W-1:0] b);
    if (b > 0 && a > SAT_HI - b) return SAT_HI;
    if (b < 0 && a < -SAT_HI - b) return -SAT_HI;
    return a + b;
  endfunction

  // acc * x scaled back by the fraction bits, truncated toward zero
  function automatic logic signed [ACC_W-1:0] sat_scale(input logic signed [ACC_W-1:0] acc,
                                                        input logic signed [ACC_W-1:0] x);
    logic neg;
    logic [ACC_W-1:0] ma, mx, hp, lp, t, u, r;
    neg = (acc < 0) != (x < 0);
    ma = (acc < 0) ? -acc : acc;
    mx = (x < 0) ? -x : x;
    hp = (ma >> 32) * mx;
    lp = (ma & 64'hFFFF_FFFF) * mx;
    if (hp > (MAG_TOP >> MUL_SHIFT)) begin
      r = MAG_TOP;
    end else begin
      t = hp << MUL_SHIFT;
      u = lp >> FRAC_BITS;
      r = (t > MAG_TOP - u) ? MAG_TOP : t + u;
    end
    return neg ? -$signed(r) : $signed(r);
  endfunction

  // horner: 2x^4 - 5x^3 + x^2 + 4x - 4
  function automatic logic signed [ACC_W-1:0] quartic_at(input logic signed [ACC_W-1:0] x);
    logic signed [ACC_W-1:0] acc;
    acc = 2 * Q_ONE;
    acc = sat_sum(sat_scale(acc, x), -5 * Q_ONE);
    acc = sat_sum(sat_scale(acc, x), Q_ONE);
    acc = sat_sum(sat_scale(acc, x), 4 * Q_ONE);
    acc = sat_sum(sat_scale(acc, x), -4 * Q_ONE);
    return acc;
  endfunction

  function automatic bisect_result_t bisect_interval(input logic signed [X_W-1:0] lower,
                                                     input logic signed [X_W-1:0] upper,
                                                     input logic [TOL_W-1:0] tol);
    logic signed [ACC_W-1:0] lo, hi, mid, p_lo, p_mid;
    logic [ACC_W-1:0] mag;
    int steps;
    logic met;
    bisect_result_t res;
    lo = lower;
    hi = upper;
    mid = (lo + hi) >>> 1;
    steps = 0;
    met = 1'b0;
    while (steps < MAX_ITERATIONS && !met) begin
      p_lo = quartic_at(lo);
      p_mid = quartic_at(mid);
      // a zero on either side keeps the interval as it is
      if (p_lo != 0 && p_mid != 0) begin
        if ((p_lo < 0) == (p_mid < 0)) lo = mid;
        else hi = mid;
      end
      mid = (lo + hi) >>> 1;
      steps++;
      p_mid = quartic_at(mid);
      mag = (p_mid < 0) ? -p_mid : p_mid;
      met = (mag <= tol);
    end
    res.root = mid[X_W-1:0];
    res.iterations = ITER_W'(steps);
    res.converged = met;
    return res;
  endfunction

  // ------------------------------------------------------------- stimulus

  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      calm = $urandom_range(4, 16);
      return 0;
    end
    return $urandom_range(0, 12);
  endfunction

  task automatic push_interval(input logic signed [X_W-1:0] lower,
                               input logic signed [X_W-1:0] upper);
    interval_t item;
    item.lower = lower;
    item.upper = upper;
    pending_intervals.push_back(item);
  endtask

  // mostly intervals around one of the real roots (-1 and 2), some that
  // miss the sign change, some raw full-range values
  task automatic push_random_interval();
    int pick, root_q, span_a, span_b;
    logic signed [X_W-1:0] a, b, t;
    pick = $urandom_range(0, 9);
    root_q = $urandom_range(0, 1) ? 2 * Q1 : -Q1;
    span_a = $urandom_range(1, 1 << $urandom_range(4, 25));
    span_b = $urandom_range(1, 1 << $urandom_range(4, 25));
    if (pick < 7) begin
      a = root_q - span_a;
      b = root_q + span_b;
    end else if (pick < 8) begin
      a = root_q + span_a;
      b = root_q + span_a + span_b;
    end else begin
      a = $urandom();
      b = $urandom();
    end
    if ($urandom_range(0, 7) == 0) begin
      t = a;
      a = b;
      b = t;
    end
    push_interval(a, b);
  endtask

  task automatic wait_drained();
    while (!(pending_intervals.size() == 0 && !holding && pending_roots.size() == 0))
      @(negedge clk);
  endtask

  task automatic write_tolerance(input logic [TOL_W-1:0] value);
    @(negedge clk);
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [TOL_W-1:0] tol;
    // exact roots, brackets, no sign change, reversed, degenerate, extremes
    push_interval(0, 4 * Q1);
    push_interval(-2 * Q1, 0);
    push_interval(-3 * Q1, 0);
    push_interval(Q1, 5 * Q1);
    push_interval(3 * Q1 / 2, 5 * Q1 / 2);
    push_interval(3 * Q1, 5 * Q1);
    push_interval(4 * Q1, Q1);
    push_interval(2 * Q1, 2 * Q1);
    push_interval(0, 0);
    push_interval(-1, 1);
    push_interval(X_MIN, X_MAX);
    push_interval(X_MAX, X_MIN);
    push_interval(X_MAX, X_MAX);
    push_interval(X_MIN, X_MIN);
    push_interval(X_MIN, 0);
    push_interval(0, X_MAX);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    wait_drained();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       tol = TOL_TOP;
        1:       tol = '0;
        5:       tol = TOL_RESET;
        default: tol = $urandom_range(0, 1 << $urandom_range(0, 24));
      endcase
      write_tolerance(tol);
      repeat (PHASE_ITEMS) push_random_interval();
      // sender holds off until every result of the phase is back
      wait_drained();
    end

    repeat (END_HOLD) @(posedge clk);
    if (fails == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  // ---------------------------------------------------------------- driver

  always @(negedge clk) begin
    interval_t cur;
    if (rst) begin
      in_valid <= 1'b0;
      holding = 1'b0;
      send_gap = 0;
    end else begin
      if (holding && in_taken) begin
        holding = 1'b0;
        send_gap = draw_wait(send_calm);
      end
      if (!holding) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_intervals.size() > 0) begin
          cur = pending_intervals.pop_front();
          holding = 1'b1;
          lower_bound <= cur.lower;
          upper_bound <= cur.upper;
        end
      end
      in_valid <= holding;
    end
  end

  // stall only counts down while a result is on offer
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_taken) stall_left = draw_wait(recv_calm);
      else if (out_valid && stall_left > 0) stall_left--;
      out_ready <= (stall_left == 0);
    end
  end

  // --------------------------------------------------------------- monitor

  always @(posedge clk) begin
    bisect_result_t want;
    in_taken = 1'b0;
    out_taken = 1'b0;
    if (rst) begin
      tolerance_now = TOL_RESET;
    end else begin
      if (cfg_valid && cfg_ready) tolerance_now = cfg_data;
      if (in_valid && in_ready) begin
        in_taken = 1'b1;
        pending_roots.push_back(bisect_interval(lower_bound, upper_bound, tolerance_now));
      end
      if (out_valid && out_ready) begin
        out_taken = 1'b1;
        if (pending_roots.size() == 0) begin
          $display("%0t: unexpected transaction root %0d iterations %0d converged %0d",
                   $time, root, iterations, converged);
          fails++;
        end else begin
          want = pending_roots.pop_front();
          if (root !== want.root) begin
            $display("%0t: root expected %0d, actual %0d", $time, want.root, root);
            fails++;
          end
          if (iterations !== want.iterations) begin
            $display("%0t: iterations expected %0d, actual %0d",
                     $time, want.iterations, iterations);
            fails++;
          end
          if (converged !== want.converged) begin
            $display("%0t: converged expected %0d, actual %0d",
                     $time, want.converged, converged);
            fails++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_roots.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

endmodule
